// ===== hdl/swls_pkg.sv =====
// shared types and constants of the lifo stack with linear search
`default_nettype none

package swls_pkg;

	// store geometry
	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// control states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_WAIT,
		ST_SEARCH
	} state_t;

	// memory access request from control to the entry store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/swls_if.sv =====
// request and response channel interfaces of the stack
`default_nettype none

interface swls_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [31:0] operand_value;

	modport source (output valid, output operation, output operand_value, input ready);
	modport sink (input valid, input operation, input operand_value, output ready);
endinterface

interface swls_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] popped_value;
	logic               found;

	modport source (output valid, output status, output popped_value, output found, input ready);
	modport sink (input valid, input status, input popped_value, input found, output ready);
endinterface

`default_nettype wire

// ===== hdl/swls_ram.sv =====
// entry store: one write port, one read port with registered read data
`default_nettype none

module swls_ram (
	input  wire logic                               clk,
	input  wire swls_pkg::mem_req_t                 req,
	output logic [swls_pkg::DATA_W-1:0]             rd_data
);

	logic [swls_pkg::DATA_W-1:0] mem [swls_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/stack_with_linear_search.sv =====
// lifo stack of signed 32-bit values with linear search over the stored entries
// push, empty pop and unused codes give their result in the cycle after acceptance
// pop with data: the entry store registers the read data, then the result register takes it
// search: one store read per cycle, stops on first match
// one transaction at a time; the next is taken once idle and the previous result is taken
// reset clears the fill count and control at once; store contents are not cleared
`default_nettype none

module stack_with_linear_search (
	input  wire logic   clk,
	input  wire logic   arst_n,
	swls_req_if.sink    req,
	swls_rsp_if.source  rsp
);

	localparam logic [swls_pkg::CNT_W-1:0] FULL_CNT = swls_pkg::CNT_W'(swls_pkg::DEPTH);

	swls_pkg::state_t   state_q, state_nxt;
	swls_pkg::mem_req_t mem_req;
	logic [swls_pkg::DATA_W-1:0] rd_data;

	logic [swls_pkg::CNT_W-1:0]  fill_q, fill_nxt;
	logic [swls_pkg::CNT_W-1:0]  scan_addr_q;
	logic                        scan_pend_s1;
	logic [swls_pkg::DATA_W-1:0] key_q;

	logic                        out_valid_q;
	logic [1:0]                  out_status_q;
	logic [swls_pkg::DATA_W-1:0] out_pop_q;
	logic                        out_found_q;

	logic                        accept;
	logic                        load_res;
	logic [1:0]                  res_status;
	logic [swls_pkg::DATA_W-1:0] res_pop;
	logic                        res_found;
	logic                        scan_issue;
	logic                        scan_hit;
	logic                        scan_done;
	logic                        is_full;
	logic                        is_empty;

	swls_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// handshake and scan status
	assign accept     = (state_q == swls_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign req.ready  = accept;
	assign is_full    = (fill_q == FULL_CNT);
	assign is_empty   = (fill_q == '0);
	assign scan_hit   = scan_pend_s1 && (rd_data == key_q);
	assign scan_issue = (state_q == swls_pkg::ST_SEARCH) && !scan_hit && (scan_addr_q < fill_q);
	assign scan_done  = scan_hit || (!scan_pend_s1 && (scan_addr_q == fill_q));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			swls_pkg::ST_IDLE: begin
				if (req.valid && accept) begin
					if (req.operation == swls_pkg::OP_POP && !is_empty) begin
						state_nxt = swls_pkg::ST_POP_WAIT;
					end else if (req.operation == swls_pkg::OP_SEARCH) begin
						state_nxt = swls_pkg::ST_SEARCH;
					end
				end
			end
			swls_pkg::ST_POP_WAIT: begin
				state_nxt = swls_pkg::ST_IDLE;
			end
			swls_pkg::ST_SEARCH: begin
				if (scan_done) begin
					state_nxt = swls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = swls_pkg::ST_IDLE;
			end
		endcase
	end

	// memory accesses, fill count and result generation
	always_comb begin
		mem_req    = '0;
		fill_nxt   = fill_q;
		load_res   = 1'b0;
		res_status = swls_pkg::STAT_OK;
		res_pop    = '0;
		res_found  = 1'b0;
		case (state_q)
			swls_pkg::ST_IDLE: begin
				if (req.valid && accept) begin
					case (req.operation)
						swls_pkg::OP_PUSH: begin
							load_res = 1'b1;
							if (is_full) begin
								res_status = swls_pkg::STAT_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = fill_q[swls_pkg::ADDR_W-1:0];
								mem_req.wdata = req.operand_value;
								fill_nxt      = fill_q + 1'b1;
							end
						end
						swls_pkg::OP_POP: begin
							if (is_empty) begin
								load_res   = 1'b1;
								res_status = swls_pkg::STAT_EMPTY;
								res_pop    = '1;
							end else begin
								fill_nxt      = fill_q - 1'b1;
								mem_req.re    = 1'b1;
								mem_req.raddr = fill_nxt[swls_pkg::ADDR_W-1:0];
							end
						end
						swls_pkg::OP_SEARCH: begin
							load_res = 1'b0;
						end
						default: begin
							// unused code: no state change, all-zero result
							load_res = 1'b1;
						end
					endcase
				end
			end
			swls_pkg::ST_POP_WAIT: begin
				load_res = 1'b1;
				res_pop  = rd_data;
			end
			swls_pkg::ST_SEARCH: begin
				mem_req.re    = scan_issue;
				mem_req.raddr = scan_addr_q[swls_pkg::ADDR_W-1:0];
				load_res      = scan_done;
				res_found     = scan_hit;
			end
			default: begin
				load_res = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= swls_pkg::ST_IDLE;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
			scan_addr_q  <= '0;
			scan_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			fill_q  <= fill_nxt;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == swls_pkg::ST_IDLE) begin
				scan_addr_q <= '0;
			end else if (scan_issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			scan_pend_s1 <= scan_issue;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && req.valid) begin
			key_q <= req.operand_value;
		end
		if (load_res) begin
			out_status_q <= res_status;
			out_pop_q    <= res_pop;
			out_found_q  <= res_found;
		end
	end

	// response channel
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.popped_value = out_pop_q;
	assign rsp.found        = out_found_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten before it was taken");

	a_fill_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.valid && req.ready) |=> $stable(fill_q))
		else $error("fill count changed without a transaction");

	a_pop_wait_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swls_pkg::ST_POP_WAIT) |-> ($past(fill_q) == fill_q + 1'b1))
		else $error("pop read without a fill count decrement");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swls_pkg::ST_SEARCH) |-> (scan_addr_q <= fill_q))
		else $error("search address ran past the fill count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the lifo stack with linear search
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// code with no operation behind it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one expected response transaction
	typedef struct {
		swls_pkg::status_t  status;
		logic signed [31:0] popped_value;
		logic               found;
	} stack_rsp_t;

	// mirror of the stack contents and the queue of responses still owed
	class stack_scoreboard;
		logic signed [31:0] entries [swls_pkg::DEPTH];
		int                 level;
		int                 deepest;
		stack_rsp_t         owed[$];
		int                 errors;
		int                 n_checked;
		int                 n_full;
		int                 n_empty;
		int                 n_hit;
		int                 n_miss;

		function bit holds(logic signed [31:0] key);
			for (int i = 0; i < level; i++) begin
				if (entries[i] == key)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// apply an accepted request to the mirror and queue its response
		function void note_request(logic [1:0] op, logic signed [31:0] value);
			stack_rsp_t want;
			want.status       = swls_pkg::STAT_OK;
			want.popped_value = 32'sd0;
			want.found        = 1'b0;
			case (op)
				swls_pkg::OP_PUSH: begin
					if (level >= swls_pkg::DEPTH) begin
						want.status = swls_pkg::STAT_FULL;
						n_full++;
					end else begin
						entries[level] = value;
						level++;
						if (level > deepest)
							deepest = level;
					end
				end
				swls_pkg::OP_POP: begin
					if (level == 0) begin
						want.status       = swls_pkg::STAT_EMPTY;
						want.popped_value = -32'sd1;
						n_empty++;
					end else begin
						level--;
						want.popped_value = entries[level];
					end
				end
				swls_pkg::OP_SEARCH: begin
					want.found = holds(value);
					if (want.found)
						n_hit++;
					else
						n_miss++;
				end
				default: ;
			endcase
			owed.push_back(want);
		endfunction

		// compare a response transaction with the oldest one owed
		function void check_response(logic [1:0] status, logic signed [31:0] popped,
				logic found);
			stack_rsp_t want;
			n_checked++;
			if (owed.size() == 0) begin
				$display("%0t: response with none owed: status %0d popped %0d found %0d",
					$time, status, popped, found);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				errors++;
			end
			if (popped !== want.popped_value) begin
				$display("%0t: popped_value expected %0d actual %0d", $time,
					want.popped_value, popped);
				errors++;
			end
			if (found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, found);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;

	stack_scoreboard sb = new();

	swls_req_if req_ch();
	swls_rsp_if rsp_ch();

	stack_with_linear_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random back-pressure on the response side
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watch both channels
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.operation, req_ch.operand_value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.status, rsp_ch.popped_value, rsp_ch.found);
	end

	// operand values biased to extremes and a small pool of duplicates
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sd0;
			3:       return -32'sd1;
			4, 5:    return 32'($urandom_range(7));
			default: return 32'($urandom);
		endcase
	endfunction

	// search keys hit a stored entry about half the time
	function automatic logic signed [31:0] search_key();
		if (sb.level > 0 && $urandom_range(1))
			return sb.entries[$urandom_range(sb.level - 1)];
		return pick_value();
	endfunction

	// present one request transaction, with random idle cycles ahead of it
	task automatic send_request(logic [1:0] op, logic signed [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid         <= 1'b0;
			req_ch.operation     <= 2'($urandom);
			req_ch.operand_value <= 32'($urandom);
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.operation     <= op;
		req_ch.operand_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// stop sending and wait until every owed response has been taken
	task automatic wait_settled();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed.size() != 0);
	endtask

	// random mix that drifts the fill level toward a target
	task automatic random_mix(int n_items, int target);
		int                 roll;
		logic [1:0]         op;
		logic signed [31:0] value;
		repeat (n_items) begin
			roll = $urandom_range(99);
			if (roll < 4)
				op = OP_UNUSED;
			else if (roll < 22)
				op = swls_pkg::OP_SEARCH;
			else if ((roll < 70) == (sb.level < target))
				op = swls_pkg::OP_PUSH;
			else
				op = swls_pkg::OP_POP;
			value = (op == swls_pkg::OP_SEARCH) ? search_key() : pick_value();
			send_request(op, value);
		end
	endtask

	// main sequence
	initial begin
		int                 fill;
		logic signed [31:0] absent_key;

		req_ch.valid         <= 1'b0;
		req_ch.operation     <= swls_pkg::OP_PUSH;
		req_ch.operand_value <= 32'sd0;
		arst_n               <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, duplicates, unused code
		send_request(swls_pkg::OP_POP, 32'sd5);
		send_request(swls_pkg::OP_SEARCH, 32'sd0);
		send_request(OP_UNUSED, -32'sd1);
		send_request(swls_pkg::OP_PUSH, 32'sh8000_0000);
		send_request(swls_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_request(swls_pkg::OP_PUSH, 32'sd0);
		send_request(swls_pkg::OP_PUSH, -32'sd1);
		send_request(swls_pkg::OP_PUSH, 32'sh5555_5555);
		send_request(swls_pkg::OP_PUSH, 32'shAAAA_AAAA);
		send_request(swls_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_request(swls_pkg::OP_SEARCH, 32'sh8000_0000);
		send_request(swls_pkg::OP_SEARCH, 32'shAAAA_AAAA);
		send_request(swls_pkg::OP_SEARCH, 32'sd1);
		send_request(OP_UNUSED, 32'sh7fff_ffff);
		send_request(swls_pkg::OP_SEARCH, -32'sd1);
		repeat (7) send_request(swls_pkg::OP_POP, 32'($urandom));
		send_request(swls_pkg::OP_POP, 32'sd0);
		send_request(swls_pkg::OP_SEARCH, 32'sh7fff_ffff);

		// low fill: no idling, then an idle sender
		random_mix(20, 6);
		send_idle_pct = 69;
		random_mix(20, 6);
		send_idle_pct = 0;

		// fill to capacity, overflow, searches of a full store for the bottom entry, the top entry and an absent key
		wait_settled();
		fill = swls_pkg::DEPTH - sb.level;
		repeat (fill) send_request(swls_pkg::OP_PUSH, pick_value());
		repeat (3) send_request(swls_pkg::OP_PUSH, pick_value());
		wait_settled();
		do
			absent_key = 32'($urandom);
		while (sb.holds(absent_key));
		send_request(swls_pkg::OP_SEARCH, sb.entries[0]);
		send_request(swls_pkg::OP_SEARCH, sb.entries[swls_pkg::DEPTH - 1]);
		send_request(swls_pkg::OP_SEARCH, absent_key);

		// near full: stalling receiver, then both sides idling
		recv_stall_pct = 69;
		random_mix(20, swls_pkg::DEPTH - 2);
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		random_mix(20, swls_pkg::DEPTH - 2);

		wait_settled();
		repeat (30) @(posedge clk);

		$display("%0d transactions checked, %0d pushes on a full store, %0d pops on an empty store",
			sb.n_checked, sb.n_full, sb.n_empty);
		$display("%0d searches found, %0d missed, deepest fill %0d of %0d",
			sb.n_hit, sb.n_miss, sb.deepest, swls_pkg::DEPTH);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("timeout with %0d responses outstanding", sb.owed.size());
		$display("FAIL");
		$finish;
	end

endmodule
